### src/lzw_pkg.sv
package lzw_pkg;

	localparam int DICT_CODES = 4096;
	localparam int ALPHABET   = 256;
	localparam int CODE_W     = 12;
	localparam int BYTE_W     = 8;
	localparam int NIB_W      = 4;
	localparam int KEY_W      = CODE_W + BYTE_W;
	localparam int SLOT_W     = KEY_W + CODE_W;
	localparam int NF_W       = $clog2(DICT_CODES) + 1;
	// hash table kept at twice the code space so probe chains stay short
	localparam int HASH_DEPTH = 2 * DICT_CODES;
	localparam int HASH_AW    = $clog2(HASH_DEPTH);

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [HASH_AW-1:0] haddr_t;
	typedef logic [SLOT_W-1:0]  slot_t;

	function automatic haddr_t hash_key(input key_t k);
		return k[HASH_AW-1:0] ^ k[KEY_W-1 -: HASH_AW];
	endfunction

endpackage

### src/lzw_ram.sv
module lzw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### src/lzw_byte_compressor.sv
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_ready, data_byte, last_byte  | in
// output   | out_valid, out_ready, out_byte, run_last, | out
//          | stream_end                                |
//
// one byte is taken at a time: the first hash probe, then each further linear probe of the
// hash table, then each output byte (0 to 4) is handled in turn before the next byte is taken.
// probe time is set by the single hash table memory with its registered read.
// after reset and after every stream end the hash table's 2*DICT_CODES (8192) slots are
// swept clear, one slot a cycle, while in_ready stays low.
// a waiting output byte sits in its own register; the next input can be taken while it waits.
module lzw_byte_compressor (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  run_last,
	output logic                  stream_end
);
	import lzw_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_HI    = 3'd3;
	localparam logic [2:0] S_LO    = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0] state_q, state_d;
	haddr_t clr_q, clr_d;
	haddr_t addr_q, addr_d;
	key_t key_q, key_d;
	code_t prefix_q, prefix_d;
	code_t code_q, code_d;
	logic pv_q, pv_d;
	logic [NF_W-1:0] nf_q, nf_d;
	logic [NIB_W-1:0] pn_q, pn_d;
	logic np_q, np_d;
	logic [BYTE_W-1:0] byte_q, byte_d;
	logic last_q, last_d;
	logic final_q, final_d;

	logic ovalid_q;
	logic [BYTE_W-1:0] obyte_q;
	logic orl_q, ose_q;

	logic ram_we, ram_re;
	haddr_t ram_waddr, ram_raddr;
	slot_t ram_wdata, ram_rdata;

	logic push, push_rl, push_se, can_push;
	logic [BYTE_W-1:0] push_byte;
	key_t new_key;
	key_t slot_key;
	code_t slot_code;

	lzw_ram #(.WIDTH(SLOT_W), .DEPTH(HASH_DEPTH)) u_hash (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign can_push   = !ovalid_q || out_ready;
	assign new_key    = {prefix_q, data_byte};
	assign slot_key   = ram_rdata[SLOT_W-1 -: KEY_W];
	assign slot_code  = ram_rdata[CODE_W-1:0];
	assign out_valid  = ovalid_q;
	assign out_byte   = obyte_q;
	assign run_last   = orl_q;
	assign stream_end = ose_q;

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		addr_d    = addr_q;
		key_d     = key_q;
		prefix_d  = prefix_q;
		code_d    = code_q;
		pv_d      = pv_q;
		nf_d      = nf_q;
		pn_d      = pn_q;
		np_d      = np_q;
		byte_d    = byte_q;
		last_d    = last_q;
		final_d   = final_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {key_q, nf_q[CODE_W-1:0]};
		ram_re    = 1'b0;
		ram_raddr = hash_key(new_key);
		push      = 1'b0;
		push_byte = '0;
		push_rl   = 1'b0;
		push_se   = 1'b0;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == '1)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					byte_d = data_byte;
					last_d = last_byte;
					if (!pv_q) begin
						prefix_d = {{(CODE_W-BYTE_W){1'b0}}, data_byte};
						pv_d     = 1'b1;
						if (last_byte) begin
							final_d = 1'b1;
							code_d  = {{(CODE_W-BYTE_W){1'b0}}, data_byte};
							state_d = S_HI;
						end
					end else begin
						ram_re  = 1'b1;
						addr_d  = hash_key(new_key);
						key_d   = new_key;
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				if (slot_code == '0) begin
					// empty slot: pair is new
					if (nf_q < NF_W'(DICT_CODES)) begin
						ram_we = 1'b1;
						nf_d   = nf_q + 1'b1;
					end
					code_d   = prefix_q;
					prefix_d = {{(CODE_W-BYTE_W){1'b0}}, byte_q};
					final_d  = 1'b0;
					state_d  = S_HI;
				end else if (slot_key == key_q) begin
					prefix_d = slot_code;
					if (last_q) begin
						final_d = 1'b1;
						code_d  = slot_code;
						state_d = S_HI;
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					addr_d    = addr_q + 1'b1;
					ram_re    = 1'b1;
					ram_raddr = addr_q + 1'b1;
				end
			end
			S_HI: begin
				if (can_push) begin
					push = 1'b1;
					if (np_q) begin
						push_byte = {pn_q, code_q[CODE_W-1 -: NIB_W]};
						state_d   = S_LO;
					end else begin
						push_byte = code_q[CODE_W-1 -: BYTE_W];
						push_rl   = !last_q;
						pn_d      = code_q[NIB_W-1:0];
						np_d      = 1'b1;
						if (last_q && !final_q) begin
							final_d = 1'b1;
							code_d  = prefix_q;
							state_d = S_HI;
						end else if (final_q) begin
							state_d = S_FLUSH;
						end else begin
							state_d = S_IDLE;
						end
					end
				end
			end
			S_LO: begin
				if (can_push) begin
					push      = 1'b1;
					push_byte = code_q[BYTE_W-1:0];
					push_rl   = !last_q || final_q;
					push_se   = final_q;
					np_d      = 1'b0;
					if (last_q && !final_q) begin
						final_d = 1'b1;
						code_d  = prefix_q;
						state_d = S_HI;
					end else if (final_q) begin
						pv_d     = 1'b0;
						prefix_d = '0;
						nf_d     = NF_W'(ALPHABET);
						pn_d     = '0;
						final_d  = 1'b0;
						clr_d    = '0;
						state_d  = S_CLR;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (can_push) begin
					push      = 1'b1;
					push_byte = {pn_q, {(BYTE_W-NIB_W){1'b0}}};
					push_rl   = 1'b1;
					push_se   = 1'b1;
					pv_d      = 1'b0;
					prefix_d  = '0;
					nf_d      = NF_W'(ALPHABET);
					pn_d      = '0;
					np_d      = 1'b0;
					final_d   = 1'b0;
					clr_d     = '0;
					state_d   = S_CLR;
				end
			end
			default: begin
				state_d = S_CLR;
				clr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			prefix_q <= '0;
			pv_q     <= 1'b0;
			nf_q     <= NF_W'(ALPHABET);
			pn_q     <= '0;
			np_q     <= 1'b0;
			last_q   <= 1'b0;
			final_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			prefix_q <= prefix_d;
			pv_q     <= pv_d;
			nf_q     <= nf_d;
			pn_q     <= pn_d;
			np_q     <= np_d;
			last_q   <= last_d;
			final_q  <= final_d;
			if (push)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		key_q  <= key_d;
		code_q <= code_d;
		byte_q <= byte_d;
		if (push) begin
			obyte_q <= push_byte;
			orl_q   <= push_rl;
			ose_q   <= push_se;
		end
	end

endmodule
